/* sv/wps_pkg.sv */
// Shared types, codes and helpers for the WAV PCM16 stream parser.
package wps_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_SIZE_PCM  = 32'd16;
  localparam logic [31:0] AUDIO_FMT_PCM = 32'd1;
  localparam logic [31:0] BITS_PCM16    = 32'd16;
  localparam logic [15:0] CHANS_STEREO  = 16'd2;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_FMT, PH_FSIZE, PH_AFMT, PH_CHAN, PH_RATE,
    PH_BRATE, PH_ALIGN, PH_BITS, PH_CID, PH_CSIZE, PH_SKIP, PH_DATA, PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    K_SAMPLE = 2'd0,
    K_HEADER = 2'd1,
    K_ERROR  = 2'd2,
    K_END    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    E_RIFF      = 3'd0,
    E_WAVE      = 3'd1,
    E_FMT_TAG   = 3'd2,
    E_FMT_SIZE  = 3'd3,
    E_FORMAT    = 3'd4,
    E_BITS      = 3'd5,
    E_BYTE_RATE = 3'd6,
    E_ZERO_CHAN = 3'd7
  } err_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] sample_value;
    logic [31:0]        rate_hz;
    logic [15:0]        channel_total;
    err_t               error_code;
    logic               last;
  } result_t;

  // Results produced by one accepted byte (zero, one or two).
  typedef struct packed {
    logic [1:0] count;
    result_t    item0;
    result_t    item1;
  } front_out_t;

  function automatic result_t mk_result(kind_t k, logic [15:0] smp, logic [31:0] rate,
                                        logic [15:0] ch, err_t err);
    result_t r;
    r.kind          = k;
    r.sample_value  = smp;
    r.rate_hz       = rate;
    r.channel_total = ch;
    r.error_code    = err;
    r.last          = 1'b1;
    return r;
  endfunction

endpackage

/* sv/wav_pcm16_stream_parser_core.sv */
// Top level of the WAV PCM16 stream parser.
// Takes one file byte per transaction (tuser marks the first byte of a new file) and
// returns header, sample, end and error results. A byte is accepted whenever the
// four-entry result queue has room for two results, so the input runs at one byte per
// cycle while the output side keeps up; the output stage hands out one result per cycle
// while m_axis_tready is high. A result is written into the queue, then registered in
// the output stage before it is offered. The byte-rate check uses a registered 32x16
// multiply formed while the following fields stream in.
module wav_pcm16_stream_parser_core import wps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] new_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [15:0] sample_value, [47:16] rate_hz,
                                      // [63:48] channel_total, [66:64] error_code
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last result of its byte
);

  front_out_t fout;
  logic       room;
  logic       head_valid;
  result_t    head;
  logic       pop;
  logic       accept;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  wps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_axis_tdata),
    .new_file  (s_axis_tuser[0]),
    .fout      (fout)
  );

  wps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fout),
    .pop        (pop),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  wps_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* sv/wps_front.sv */
// Byte parser: walks the RIFF/WAVE header, checks it and turns data bytes into results.
module wps_front import wps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       new_file,
  output front_out_t fout
);

  phase_t      phase, phase_next;
  logic [1:0]  bif, bif_next;
  logic [31:0] accum, accum_next;
  logic [15:0] chans, chans_next;
  logic [31:0] rate, rate_next;
  logic [31:0] brate, brate_next;
  logic [31:0] remaining, remaining_next;
  logic [15:0] chan_idx, chan_idx_next;
  logic [7:0]  low_byte, low_byte_next;
  logic [15:0] left_smp, left_smp_next;
  logic [47:0] prod;

  phase_t      ph;
  logic [1:0]  b_i;
  logic [31:0] acc;
  logic [31:0] v;
  logic [31:0] rem_dec;
  logic [15:0] raw;
  logic [15:0] ci1;
  logic signed [16:0] pair_sum;
  logic signed [16:0] pair_adj;
  logic        len2;
  logic        field_done;
  logic        frame_done;
  logic [1:0]  n;
  result_t     outs [2];

  // rate*channels is ready long before the bits field closes
  always_ff @(posedge clk) begin
    prod <= rate * chans;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_RIFF;
      bif   <= '0;
      accum <= '0;
    end else begin
      phase <= phase_next;
      bif   <= bif_next;
      accum <= accum_next;
    end
    chans     <= chans_next;
    rate      <= rate_next;
    brate     <= brate_next;
    remaining <= remaining_next;
    chan_idx  <= chan_idx_next;
    low_byte  <= low_byte_next;
    left_smp  <= left_smp_next;
  end

  always_comb begin
    ph  = new_file ? PH_RIFF : phase;
    b_i = new_file ? 2'd0 : bif;
    acc = new_file ? 32'd0 : accum;

    phase_next     = phase;
    bif_next       = bif;
    accum_next     = accum;
    chans_next     = chans;
    rate_next      = rate;
    brate_next     = brate;
    remaining_next = remaining;
    chan_idx_next  = chan_idx;
    low_byte_next  = low_byte;
    left_smp_next  = left_smp;

    v          = acc | (32'(data_byte) << {b_i, 3'b000});
    rem_dec    = remaining - 32'd1;
    raw        = {data_byte, low_byte};
    ci1        = chan_idx + 16'd1;
    pair_sum   = 17'(signed'(left_smp)) + 17'(signed'(raw));
    pair_adj   = pair_sum + 17'(pair_sum[16]);
    len2       = (ph == PH_AFMT) || (ph == PH_CHAN) || (ph == PH_ALIGN) || (ph == PH_BITS);
    field_done = len2 ? (b_i == 2'd1) : (b_i == 2'd3);
    frame_done = 1'b0;
    n          = 2'd0;
    outs[0]    = '0;
    outs[1]    = '0;

    if (accept) begin
      phase_next = ph;
      bif_next   = b_i;
      accum_next = acc;
      case (ph)
        PH_HALT: begin
        end
        PH_DATA: begin
          remaining_next = rem_dec;
          if (b_i == 2'd0) begin
            low_byte_next = data_byte;
            bif_next      = 2'd1;
          end else begin
            bif_next = 2'd0;
            if (chans == CHANS_STEREO) begin
              if (chan_idx == 16'd0) begin
                left_smp_next = raw;
                chan_idx_next = 16'd1;
              end else begin
                // average truncates toward zero
                outs[n[0]]    = mk_result(K_SAMPLE, pair_adj[16:1], '0, '0, E_RIFF);
                n             = n + 2'd1;
                chan_idx_next = 16'd0;
                frame_done    = 1'b1;
              end
            end else begin
              outs[n[0]] = mk_result(K_SAMPLE, raw, '0, '0, E_RIFF);
              n          = n + 2'd1;
              if (ci1 >= chans) begin
                chan_idx_next = 16'd0;
                frame_done    = 1'b1;
              end else begin
                chan_idx_next = ci1;
              end
            end
            if (frame_done && (rem_dec < {15'd0, chans, 1'b0})) begin
              outs[n[0]] = mk_result(K_END, '0, '0, '0, E_RIFF);
              n          = n + 2'd1;
              phase_next = PH_HALT;
            end
          end
        end
        PH_SKIP: begin
          remaining_next = rem_dec;
          if (rem_dec == 32'd0) phase_next = PH_CID;
        end
        default: begin
          if (!field_done) begin
            bif_next   = b_i + 2'd1;
            accum_next = v;
          end else begin
            bif_next   = 2'd0;
            accum_next = '0;
            case (ph)
              PH_RIFF: begin
                if (v != TAG_RIFF) begin
                  outs[n[0]] = mk_result(K_ERROR, '0, '0, '0, E_RIFF);
                  n = n + 2'd1;
                  phase_next = PH_HALT;
                end else phase_next = PH_RSIZE;
              end
              PH_RSIZE: phase_next = PH_WAVE;
              PH_WAVE: begin
                if (v != TAG_WAVE) begin
                  outs[n[0]] = mk_result(K_ERROR, '0, '0, '0, E_WAVE);
                  n = n + 2'd1;
                  phase_next = PH_HALT;
                end else phase_next = PH_FMT;
              end
              PH_FMT: begin
                if (v != TAG_FMT) begin
                  outs[n[0]] = mk_result(K_ERROR, '0, '0, '0, E_FMT_TAG);
                  n = n + 2'd1;
                  phase_next = PH_HALT;
                end else phase_next = PH_FSIZE;
              end
              PH_FSIZE: begin
                if (v != FMT_SIZE_PCM) begin
                  outs[n[0]] = mk_result(K_ERROR, '0, '0, '0, E_FMT_SIZE);
                  n = n + 2'd1;
                  phase_next = PH_HALT;
                end else phase_next = PH_AFMT;
              end
              PH_AFMT: begin
                if (v != AUDIO_FMT_PCM) begin
                  outs[n[0]] = mk_result(K_ERROR, '0, '0, '0, E_FORMAT);
                  n = n + 2'd1;
                  phase_next = PH_HALT;
                end else phase_next = PH_CHAN;
              end
              PH_CHAN: begin
                chans_next = v[15:0];
                if (v == 32'd0) begin
                  outs[n[0]] = mk_result(K_ERROR, '0, '0, '0, E_ZERO_CHAN);
                  n = n + 2'd1;
                  phase_next = PH_HALT;
                end else phase_next = PH_RATE;
              end
              PH_RATE: begin
                rate_next  = v;
                phase_next = PH_BRATE;
              end
              PH_BRATE: begin
                brate_next = v;
                phase_next = PH_ALIGN;
              end
              PH_ALIGN: phase_next = PH_BITS;
              PH_BITS: begin
                if (v != BITS_PCM16) begin
                  outs[n[0]] = mk_result(K_ERROR, '0, '0, '0, E_BITS);
                  n = n + 2'd1;
                  phase_next = PH_HALT;
                end else if ({17'd0, brate} != {prod, 1'b0}) begin
                  outs[n[0]] = mk_result(K_ERROR, '0, '0, '0, E_BYTE_RATE);
                  n = n + 2'd1;
                  phase_next = PH_HALT;
                end else phase_next = PH_CID;
              end
              PH_CID: begin
                // marks a data chunk while its size is read
                remaining_next = (v == TAG_DATA) ? 32'd1 : 32'd0;
                phase_next     = PH_CSIZE;
              end
              PH_CSIZE: begin
                remaining_next = v;
                if (remaining == 32'd1) begin
                  chan_idx_next = '0;
                  outs[n[0]] = mk_result(K_HEADER, '0, rate, chans, E_RIFF);
                  n = n + 2'd1;
                  if (v < {15'd0, chans, 1'b0}) begin
                    outs[n[0]] = mk_result(K_END, '0, '0, '0, E_RIFF);
                    n = n + 2'd1;
                    phase_next = PH_HALT;
                  end else phase_next = PH_DATA;
                end else begin
                  phase_next = (v == 32'd0) ? PH_CID : PH_SKIP;
                end
              end
              default: phase_next = PH_HALT;
            endcase
          end
        end
      endcase
    end

    outs[0].last = (n == 2'd1);
    fout.count   = n;
    fout.item0   = outs[0];
    fout.item1   = outs[1];
  end

endmodule

/* sv/wps_queue.sv */
// Short result queue between parser and output stage; takes up to two results per cycle.
module wps_queue import wps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  front_out_t push,
  input  logic       pop,
  output logic       room,
  output logic       head_valid,
  output result_t    head
);

  result_t        mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;
  logic [QAW-1:0] wr_ptr1;
  logic           do_pop;

  assign wr_ptr1    = wr_ptr + QAW'(1);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;
  // room for the worst case of two results from one byte
  assign room       = (count <= (QAW+1)'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.item0;
    if (push.count == 2'd2) mem[wr_ptr1] <= push.item1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAW'(push.count);
      if (do_pop) rd_ptr <= rd_ptr + QAW'(1);
      count <= count + (QAW+1)'(push.count) - (QAW+1)'(do_pop);
    end
  end

endmodule

/* sv/wps_back.sv */
// Output stage: registers one result and presents it on the master stream.
module wps_back import wps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  result_t     head,
  output logic        pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  result_t held;
  logic    held_valid;

  assign pop = head_valid && (!held_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (pop) begin
      held_valid <= 1'b1;
    end else if (m_axis_tready) begin
      held_valid <= 1'b0;
    end
    if (pop) held <= head;
  end

  assign m_axis_tvalid = held_valid;
  assign m_axis_tdata  = {5'd0, held.error_code, held.channel_total, held.rate_hz,
                          held.sample_value};
  assign m_axis_tuser  = held.kind;
  assign m_axis_tlast  = held.last;

endmodule
